/* rtl/core/epq_pkg.sv */
// Shared constants for the entry pool priority queue manager.
// Field widths, request kind codes and parameter defaults; no dependencies.
`default_nettype none

package epq_pkg;

	localparam int KIND_W = 3;
	localparam int QSEL_W = 3;
	localparam int ENT_W  = 5;
	localparam int PRIO_W = 16;

	localparam int POOL_SIZE_DEF   = 32;
	localparam int QUEUE_COUNT_DEF = 8;

	localparam logic [KIND_W-1:0] KIND_ALLOC  = 3'd0;
	localparam logic [KIND_W-1:0] KIND_FREE   = 3'd1;
	localparam logic [KIND_W-1:0] KIND_INSERT = 3'd2;
	localparam logic [KIND_W-1:0] KIND_PEEK   = 3'd3;
	localparam logic [KIND_W-1:0] KIND_POP    = 3'd4;
	localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd5;

endpackage

`default_nettype wire

/* rtl/core/epq_if.sv */
// Request and response channel interfaces of the queue manager.
// Depends on epq_pkg for field widths.
`default_nettype none

interface epq_req_if;
	import epq_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [KIND_W-1:0]        kind;
	logic [QSEL_W-1:0]        queue_select;
	logic [ENT_W-1:0]         entry_index;
	logic signed [PRIO_W-1:0] entry_priority;

	modport source (output valid, kind, queue_select, entry_index, entry_priority,
		input ready);
	modport sink (input valid, kind, queue_select, entry_index, entry_priority,
		output ready);
endinterface

interface epq_rsp_if;
	import epq_pkg::*;

	logic             valid;
	logic             ready;
	logic [ENT_W-1:0] result_index;
	logic             result_valid;

	modport source (output valid, result_index, result_valid, input ready);
	modport sink (input valid, result_index, result_valid, output ready);
endinterface

`default_nettype wire

/* rtl/core/entry_pool_priority_queues_core.sv */
// Queue manager: free list and sorted priority queues over a shared entry pool.
// Depends on epq_pkg and the channel interfaces in epq_if.sv.
//
//   channel | dir | handshake     | payload
//   req     | in  | valid / ready | kind, queue_select, entry_index, entry_priority
//   rsp     | out | valid / ready | result_index, result_valid
//
// One request at a time; ready is high only while the sequencer is idle.
// Insert and remove walk the queue link by link: each walked link costs one
// registered read of the link memory, and insert adds one of the priority memory.
// Reset needs no clearing pass: per-entry valid bits supply the reset contents.
// A finished response waits in the output register while the next request runs.
`default_nettype none

module entry_pool_priority_queues_core #(
	parameter int POOL_SIZE   = epq_pkg::POOL_SIZE_DEF,
	parameter int QUEUE_COUNT = epq_pkg::QUEUE_COUNT_DEF
) (
	input  wire        clk,
	input  wire        arst_n,
	epq_req_if.sink    req,
	epq_rsp_if.source  rsp
);
	import epq_pkg::*;

	localparam int IW = $clog2(POOL_SIZE);
	localparam int LW = IW + 1;
	localparam int SW = $clog2(POOL_SIZE + 1);
	localparam int QW = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
	localparam logic [LW-1:0] NONE = {LW{1'b1}};

	typedef enum logic [14:0] {
		S_IDLE   = 15'b000000000000001,
		S_DISP   = 15'b000000000000010,
		S_ALINK  = 15'b000000000000100,
		S_PLINK  = 15'b000000000001000,
		S_IRDH   = 15'b000000000010000,
		S_IPRIOH = 15'b000000000100000,
		S_ILINK  = 15'b000000001000000,
		S_ICMP   = 15'b000000010000000,
		S_IW1    = 15'b000000100000000,
		S_IW2    = 15'b000001000000000,
		S_RHEAD  = 15'b000010000000000,
		S_RCHK   = 15'b000100000000000,
		S_RLNK   = 15'b001000000000000,
		S_RCLR   = 15'b010000000000000,
		S_DONE   = 15'b100000000000000
	} state_t;

	state_t state_q, state_d;

	// latched request
	logic [KIND_W-1:0]        kind_q;
	logic [QW-1:0]            q_q;
	logic [IW-1:0]            e_q;
	logic signed [PRIO_W-1:0] pr_q;
	logic                     qok_q, eok_q;

	// walk registers
	logic [LW-1:0] cur_q, cur_d;
	logic [LW-1:0] nxt_q, nxt_d;
	logic [SW-1:0] steps_q, steps_d;

	logic [LW-1:0] fh_q, fh_d;
	logic [LW-1:0] qhead_q [QUEUE_COUNT];
	logic          qh_we;
	logic [LW-1:0] qh_wd;

	logic [IW-1:0] res_q, res_d;
	logic          resv_q, resv_d;

	logic             rsp_valid_q;
	logic [ENT_W-1:0] rsp_idx_q;
	logic             rsp_rv_q;
	logic             out_load;

	// link and priority memories
	logic [LW-1:0]            link_mem [POOL_SIZE];
	logic signed [PRIO_W-1:0] prio_mem [POOL_SIZE];
	logic [POOL_SIZE-1:0]     lvalid_q, pvalid_q;

	logic                     lw_en, pw_en;
	logic [IW-1:0]            lw_addr, pw_addr, lr_addr, pr_addr;
	logic [LW-1:0]            lw_data;
	logic signed [PRIO_W-1:0] pw_data;

	logic [LW-1:0]            link_rd_q;
	logic [IW-1:0]            link_ra_q;
	logic                     link_rv_q;
	logic signed [PRIO_W-1:0] prio_rd_q;
	logic                     prio_rv_q;

	logic [LW-1:0]            link_val;
	logic signed [PRIO_W-1:0] prio_val;
	logic                     prio_gt;
	logic [LW-1:0]            h;
	logic [LW-1:0]            e_link;

	assign link_val = link_rv_q ? link_rd_q :
		((link_ra_q == IW'(POOL_SIZE - 1)) ? NONE : {1'b0, IW'(link_ra_q + 1'b1)});
	assign prio_val = prio_rv_q ? prio_rd_q : '0;
	assign prio_gt  = pr_q > prio_val;
	assign h        = qhead_q[q_q];
	assign e_link   = {1'b0, e_q};

	assign req.ready        = (state_q == S_IDLE);
	assign out_load         = (state_q == S_DONE) && (!rsp_valid_q || rsp.ready);
	assign rsp.valid        = rsp_valid_q;
	assign rsp.result_index = rsp_idx_q;
	assign rsp.result_valid = rsp_rv_q;

	always_comb begin
		state_d = state_q;
		cur_d   = cur_q;
		nxt_d   = nxt_q;
		steps_d = steps_q;
		fh_d    = fh_q;
		qh_we   = 1'b0;
		qh_wd   = NONE;
		lw_en   = 1'b0;
		lw_addr = e_q;
		lw_data = NONE;
		pw_en   = 1'b0;
		pw_addr = e_q;
		pw_data = pr_q;
		lr_addr = e_q;
		pr_addr = e_q;
		res_d   = res_q;
		resv_d  = resv_q;
		case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				resv_d  = 1'b0;
				res_d   = '0;
				state_d = S_DONE;
				case (kind_q)
					KIND_ALLOC: begin
						if (!fh_q[LW-1]) begin
							cur_d   = fh_q;
							lr_addr = fh_q[IW-1:0];
							state_d = S_ALINK;
						end
					end
					KIND_FREE: begin
						if (eok_q) begin
							lw_en   = 1'b1;
							lw_data = fh_q;
							fh_d    = e_link;
						end
					end
					KIND_INSERT: begin
						if (qok_q && eok_q) begin
							pw_en = 1'b1;
							if (h[LW-1]) begin
								lw_en = 1'b1;
								qh_we = 1'b1;
								qh_wd = e_link;
							end else begin
								cur_d   = h;
								state_d = S_IRDH;
							end
						end
					end
					KIND_PEEK: begin
						if (qok_q && !h[LW-1]) begin
							resv_d = 1'b1;
							res_d  = h[IW-1:0];
						end
					end
					KIND_POP: begin
						if (qok_q && !h[LW-1]) begin
							cur_d   = h;
							lr_addr = h[IW-1:0];
							state_d = S_PLINK;
						end
					end
					KIND_REMOVE: begin
						if (qok_q && eok_q && !h[LW-1]) begin
							if (h == e_link) begin
								state_d = S_RHEAD;
							end else begin
								cur_d   = h;
								steps_d = '0;
								lr_addr = h[IW-1:0];
								state_d = S_RCHK;
							end
						end
					end
					default: begin
					end
				endcase
			end
			S_ALINK: begin
				fh_d    = link_val;
				lw_en   = 1'b1;
				lw_addr = cur_q[IW-1:0];
				pw_en   = 1'b1;
				pw_addr = cur_q[IW-1:0];
				pw_data = '0;
				resv_d  = 1'b1;
				res_d   = cur_q[IW-1:0];
				state_d = S_DONE;
			end
			S_PLINK: begin
				qh_we   = 1'b1;
				qh_wd   = link_val;
				lw_en   = 1'b1;
				lw_addr = cur_q[IW-1:0];
				resv_d  = 1'b1;
				res_d   = cur_q[IW-1:0];
				state_d = S_DONE;
			end
			S_IRDH: begin
				pr_addr = cur_q[IW-1:0];
				state_d = S_IPRIOH;
			end
			S_IPRIOH: begin
				if (prio_gt) begin
					lw_en   = 1'b1;
					lw_data = cur_q;
					qh_we   = 1'b1;
					qh_wd   = e_link;
					state_d = S_DONE;
				end else begin
					steps_d = '0;
					lr_addr = cur_q[IW-1:0];
					state_d = S_ILINK;
				end
			end
			S_ILINK: begin
				nxt_d = link_val;
				if (link_val[LW-1]) begin
					state_d = S_IW1;
				end else begin
					pr_addr = link_val[IW-1:0];
					state_d = S_ICMP;
				end
			end
			S_ICMP: begin
				if (prio_gt || steps_q == SW'(POOL_SIZE)) begin
					state_d = S_IW1;
				end else begin
					cur_d   = nxt_q;
					steps_d = steps_q + 1'b1;
					lr_addr = nxt_q[IW-1:0];
					state_d = S_ILINK;
				end
			end
			S_IW1: begin
				lw_en   = 1'b1;
				lw_data = nxt_q;
				state_d = S_IW2;
			end
			S_IW2: begin
				lw_en   = 1'b1;
				lw_addr = cur_q[IW-1:0];
				lw_data = e_link;
				state_d = S_DONE;
			end
			S_RHEAD: begin
				qh_we   = 1'b1;
				qh_wd   = link_val;
				lw_en   = 1'b1;
				resv_d  = 1'b1;
				res_d   = e_q;
				state_d = S_DONE;
			end
			S_RCHK: begin
				if (link_val[LW-1]) begin
					state_d = S_DONE;
				end else if (link_val == e_link) begin
					state_d = S_RLNK;
				end else if (steps_q == SW'(POOL_SIZE - 1)) begin
					state_d = S_DONE;
				end else begin
					steps_d = steps_q + 1'b1;
					cur_d   = link_val;
					lr_addr = link_val[IW-1:0];
				end
			end
			S_RLNK: begin
				lw_en   = 1'b1;
				lw_addr = cur_q[IW-1:0];
				lw_data = link_val;
				state_d = S_RCLR;
			end
			S_RCLR: begin
				lw_en   = 1'b1;
				resv_d  = 1'b1;
				res_d   = e_q;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fh_q        <= '0;
			lvalid_q    <= '0;
			pvalid_q    <= '0;
			rsp_valid_q <= 1'b0;
			for (int i = 0; i < QUEUE_COUNT; i++) begin
				qhead_q[i] <= NONE;
			end
		end else begin
			state_q <= state_d;
			fh_q    <= fh_d;
			if (qh_we) begin
				qhead_q[q_q] <= qh_wd;
			end
			if (lw_en) begin
				lvalid_q[lw_addr] <= 1'b1;
			end
			if (pw_en) begin
				pvalid_q[pw_addr] <= 1'b1;
			end
			if (out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			kind_q <= req.kind;
			q_q    <= QW'(req.queue_select);
			e_q    <= IW'(req.entry_index);
			pr_q   <= req.entry_priority;
			qok_q  <= 32'(req.queue_select) < 32'(QUEUE_COUNT);
			eok_q  <= 32'(req.entry_index) < 32'(POOL_SIZE);
		end
		cur_q   <= cur_d;
		nxt_q   <= nxt_d;
		steps_q <= steps_d;
		res_q   <= res_d;
		resv_q  <= resv_d;
		if (out_load) begin
			rsp_idx_q <= resv_q ? ENT_W'(res_q) : '0;
			rsp_rv_q  <= resv_q;
		end
	end

	always_ff @(posedge clk) begin
		if (lw_en) begin
			link_mem[lw_addr] <= lw_data;
		end
		link_rd_q <= link_mem[lr_addr];
		link_ra_q <= lr_addr;
		link_rv_q <= lvalid_q[lr_addr];
	end

	always_ff @(posedge clk) begin
		if (pw_en) begin
			prio_mem[pw_addr] <= pw_data;
		end
		prio_rd_q <= prio_mem[pr_addr];
		prio_rv_q <= pvalid_q[pr_addr];
	end

`ifndef SYNTHESIS
	a_accept_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> state_q == S_DISP)
		else $error("accepted request did not reach dispatch");

	a_steps_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ICMP || state_q == S_RCHK) |-> steps_q <= SW'(POOL_SIZE))
		else $error("walk step count beyond pool size");

	a_free_head_range: assert property (@(posedge clk) disable iff (!arst_n)
		!fh_q[LW-1] |-> 32'(fh_q) < 32'(POOL_SIZE))
		else $error("free head outside the pool");

	a_done_loads: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> rsp_valid_q && state_q == S_IDLE)
		else $error("finished response not presented");

	a_none_index: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && !rsp_rv_q |-> rsp_idx_q == '0)
		else $error("none response carries an index");
`endif

endmodule

`default_nettype wire

/* tb/epq_result_check.sv */
// Response checker for the entry pool priority queue manager.
// Watches both channels, keeps its own copy of the pool and queue links and
// compares each response; depends on epq_pkg and the interfaces in epq_if.sv.
`default_nettype none

module epq_result_check (
	input  wire  clk,
	input  wire  arst_n,
	epq_req_if   req,
	epq_rsp_if   rsp,
	output int   mismatches,
	output int   pending_count
);
	timeunit 1ns;
	timeprecision 1ps;
	import epq_pkg::*;

	localparam int POOL = POOL_SIZE_DEF;
	localparam int QCNT = QUEUE_COUNT_DEF;
	localparam int LINK_W = ENT_W + 1;
	localparam logic [LINK_W-1:0] NO_LINK = '1;

	typedef struct packed {
		logic [ENT_W-1:0] index;
		logic             valid;
	} result_t;

	logic [LINK_W-1:0]        link_of [POOL];
	logic signed [PRIO_W-1:0] prio_tab [POOL];
	logic [LINK_W-1:0]        free_top;
	logic [LINK_W-1:0]        head_of [QCNT];

	result_t pending_results[$];
	result_t want;

	function automatic void reset_pool();
		for (int i = 0; i < POOL; i++) begin
			link_of[i] = (i + 1 < POOL) ? LINK_W'(i + 1) : NO_LINK;
			prio_tab[i] = '0;
		end
		free_top = '0;
		for (int i = 0; i < QCNT; i++)
			head_of[i] = NO_LINK;
	endfunction

	// queue_select and entry_index cannot exceed the pool or queue count at these widths
	function automatic result_t predict_queue_op(input logic [KIND_W-1:0] kind,
		input logic [QSEL_W-1:0] qs, input logic [ENT_W-1:0] ent,
		input logic signed [PRIO_W-1:0] pri);
		logic [LINK_W-1:0] h;
		logic [LINK_W-1:0] cur;
		logic [LINK_W-1:0] nxt;
		int                steps;
		logic              walking;
		result_t           res;

		res = '0;
		h = head_of[qs];
		case (kind)
			KIND_ALLOC: begin
				if (free_top != NO_LINK) begin
					res.index = free_top[ENT_W-1:0];
					res.valid = 1'b1;
					free_top = link_of[res.index];
					link_of[res.index] = NO_LINK;
					prio_tab[res.index] = '0;
				end
			end
			KIND_FREE: begin
				link_of[ent] = free_top;
				free_top = {1'b0, ent};
			end
			KIND_INSERT: begin
				prio_tab[ent] = pri;
				if (h == NO_LINK || pri > prio_tab[h[ENT_W-1:0]]) begin
					link_of[ent] = h;
					head_of[qs] = {1'b0, ent};
				end else begin
					// equal priorities queue behind; walk is bounded by the pool size
					cur = h;
					steps = 0;
					while (link_of[cur[ENT_W-1:0]] != NO_LINK
						&& !(pri > prio_tab[link_of[cur[ENT_W-1:0]][ENT_W-1:0]])
						&& steps < POOL) begin
						cur = link_of[cur[ENT_W-1:0]];
						steps++;
					end
					link_of[ent] = link_of[cur[ENT_W-1:0]];
					link_of[cur[ENT_W-1:0]] = {1'b0, ent};
				end
			end
			KIND_PEEK: begin
				if (h != NO_LINK) begin
					res.index = h[ENT_W-1:0];
					res.valid = 1'b1;
				end
			end
			KIND_POP: begin
				if (h != NO_LINK) begin
					res.index = h[ENT_W-1:0];
					res.valid = 1'b1;
					head_of[qs] = link_of[res.index];
					link_of[res.index] = NO_LINK;
				end
			end
			KIND_REMOVE: begin
				if (h == {1'b0, ent}) begin
					head_of[qs] = link_of[ent];
					link_of[ent] = NO_LINK;
					res.valid = 1'b1;
				end else if (h != NO_LINK) begin
					cur = h;
					walking = 1'b1;
					for (steps = 0; steps < POOL && walking; steps++) begin
						nxt = link_of[cur[ENT_W-1:0]];
						if (nxt == NO_LINK) begin
							walking = 1'b0;
						end else if (nxt == {1'b0, ent}) begin
							link_of[cur[ENT_W-1:0]] = link_of[ent];
							link_of[ent] = NO_LINK;
							res.valid = 1'b1;
							walking = 1'b0;
						end else begin
							cur = nxt;
						end
					end
				end
				if (res.valid)
					res.index = ent;
			end
			default: begin
			end
		endcase
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reset_pool();
			pending_results.delete();
			pending_count = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (pending_results.size() == 0) begin
					$error("response with no request pending: result_index %0d result_valid %0b",
						rsp.result_index, rsp.result_valid);
					mismatches++;
				end else begin
					want = pending_results.pop_front();
					if (rsp.result_valid !== want.valid) begin
						$error("result_valid: expected %0b, got %0b", want.valid, rsp.result_valid);
						mismatches++;
					end
					if (rsp.result_index !== want.index) begin
						$error("result_index: expected %0d, got %0d", want.index, rsp.result_index);
						mismatches++;
					end
				end
			end
			if (req.valid && req.ready)
				pending_results.push_back(predict_queue_op(req.kind, req.queue_select,
					req.entry_index, req.entry_priority));
			pending_count = pending_results.size();
		end
	end

endmodule

`default_nettype wire

/* tb/entry_pool_priority_queues_core_tb.sv */
// Testbench top for entry_pool_priority_queues_core: clock, reset, request
// stimulus and response backpressure; checking lives in epq_result_check.
// Depends on epq_pkg, epq_if.sv, the core and tb/epq_result_check.sv.
`default_nettype none

module entry_pool_priority_queues_core_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import epq_pkg::*;

	localparam int POOL        = POOL_SIZE_DEF;
	localparam int QCNT        = QUEUE_COUNT_DEF;
	localparam int RANDOM_REQS = 750;
	localparam int NOISE_REQS  = 40;
	localparam int STALL_AT    = 3000;
	localparam int STALL_LEN   = 400;
	localparam int QUIET_FROM  = 6000;
	localparam int QUIET_TO    = 9000;
	localparam int DRAIN_WAIT  = 80;

	localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd6;
	localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;
	localparam logic signed [PRIO_W-1:0] PRIO_TOP    = 16'sh7FFF;
	localparam logic signed [PRIO_W-1:0] PRIO_BOTTOM = 16'sh8000;

	typedef struct {
		int qs;
		int idx;
		int pri;
	} slot_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   cyc = 0;
	int   mismatches;
	int   pending_count;

	// stimulus-side view of the pool, kept only to form well-formed sequences
	int    free_stack[$];
	int    held[$];
	slot_t queued[$];

	epq_req_if req_ch ();
	epq_rsp_if rsp_ch ();

	entry_pool_priority_queues_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	epq_result_check results_chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.req           (req_ch),
		.rsp           (rsp_ch),
		.mismatches    (mismatches),
		.pending_count (pending_count)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cyc <= cyc + 1;
	end

	initial begin
		#1_000_000;
		$display("TB_ERROR");
		$finish;
	end

	function automatic bit quiet();
		return cyc >= QUIET_FROM && cyc < QUIET_TO;
	endfunction

	function automatic logic signed [PRIO_W-1:0] rand_prio();
		case ($urandom_range(2))
			0: return $urandom_range(1) ? PRIO_TOP : PRIO_BOTTOM;
			1: return PRIO_W'($urandom_range(6)) - PRIO_W'(3);
			default: return PRIO_W'($urandom);
		endcase
	endfunction

	// at least half the traffic goes to queue 0 so that it grows long
	function automatic int pick_queue();
		return $urandom_range(1) ? 0 : $urandom_range(QCNT - 1);
	endfunction

	task automatic send_req(input logic [KIND_W-1:0] k, input int q, input int e,
		input logic signed [PRIO_W-1:0] p);
		while (!quiet() && $urandom_range(99) < 11) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.kind <= k;
		req_ch.queue_select <= QSEL_W'(q);
		req_ch.entry_index <= ENT_W'(e);
		req_ch.entry_priority <= p;
		do @(posedge clk); while (!req_ch.ready);
		@(negedge clk);
	endtask

	task automatic take_held(input int e);
		foreach (held[i])
			if (held[i] == e) begin
				held.delete(i);
				return;
			end
	endtask

	task automatic req_alloc();
		if (free_stack.size() > 0)
			held.push_back(free_stack.pop_front());
		send_req(KIND_ALLOC, $urandom_range(QCNT - 1), $urandom_range(POOL - 1), rand_prio());
	endtask

	task automatic req_free(input int e);
		take_held(e);
		free_stack.push_front(e);
		send_req(KIND_FREE, $urandom_range(QCNT - 1), e, rand_prio());
	endtask

	task automatic req_insert(input int q, input int e, input logic signed [PRIO_W-1:0] p);
		int pos;
		slot_t s;

		pos = 0;
		foreach (queued[i])
			if (queued[i].qs == q && queued[i].pri >= int'(p))
				pos = i + 1;
		s.qs = q;
		s.idx = e;
		s.pri = int'(p);
		take_held(e);
		queued.insert(pos, s);
		send_req(KIND_INSERT, q, e, p);
	endtask

	task automatic req_peek(input int q);
		send_req(KIND_PEEK, q, $urandom_range(POOL - 1), rand_prio());
	endtask

	task automatic req_pop(input int q);
		foreach (queued[i])
			if (queued[i].qs == q) begin
				held.push_back(queued[i].idx);
				queued.delete(i);
				break;
			end
		send_req(KIND_POP, q, $urandom_range(POOL - 1), rand_prio());
	endtask

	task automatic req_remove(input int q, input int e);
		foreach (queued[i])
			if (queued[i].qs == q && queued[i].idx == e) begin
				held.push_back(e);
				queued.delete(i);
				break;
			end
		send_req(KIND_REMOVE, q, e, rand_prio());
	endtask

	initial begin : rsp_side
		int ticks;
		int stall_left;

		rsp_ch.ready = 1'b0;
		ticks = 0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			ticks++;
			if (ticks == STALL_AT)
				stall_left = STALL_LEN;
			if (!arst_n) begin
				rsp_ch.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= quiet() || $urandom_range(99) >= 11;
			end
		end
	end

	initial begin : req_side
		int  n;
		int  roll;
		int  i;
		bit  filling;

		req_ch.valid = 1'b0;
		req_ch.kind = KIND_ALLOC;
		req_ch.queue_select = '0;
		req_ch.entry_index = '0;
		req_ch.entry_priority = '0;
		for (int k = 0; k < POOL; k++)
			free_stack.push_back(k);

		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty queues, then extremes, equal priorities and middle/tail removal
		req_peek(0);
		req_pop(QCNT - 1);
		req_remove(3, 5);
		repeat (4) req_alloc();
		req_insert(0, 0, '0);
		req_insert(0, 1, PRIO_TOP);
		req_insert(0, 2, PRIO_BOTTOM);
		req_insert(0, 3, '0);
		req_peek(0);
		req_remove(0, 3);
		req_remove(0, 3);
		req_remove(0, 2);
		req_pop(0);
		req_pop(0);
		req_pop(0);
		send_req(KIND_SPARE_LO, 0, 0, PRIO_TOP);
		send_req(KIND_SPARE_HI, QCNT - 1, POOL - 1, PRIO_BOTTOM);
		req_free(3);
		req_free(2);
		req_free(1);
		req_free(0);
		req_alloc();
		req_insert(QCNT - 1, 0, -16'sd1);
		req_pop(QCNT - 1);

		n = 0;
		while (n < RANDOM_REQS) begin
			filling = ((n / 125) % 2) == 0;
			roll = $urandom_range(99);
			n++;
			if (roll < (filling ? 24 : 8)) begin
				req_alloc();
			end else if (roll < 32 && held.size() > 0) begin
				req_free(held[$urandom_range(held.size() - 1)]);
			end else if (roll < 60 && held.size() > 0) begin
				req_insert(pick_queue(), held[$urandom_range(held.size() - 1)], rand_prio());
			end else if (roll < 70) begin
				req_peek(pick_queue());
			end else if (roll < (filling ? 80 : 86)) begin
				req_pop(pick_queue());
			end else if (roll < 95) begin
				if (queued.size() > 0 && $urandom_range(9) < 7) begin
					i = $urandom_range(queued.size() - 1);
					req_remove(queued[i].qs, queued[i].idx);
				end else begin
					req_remove($urandom_range(QCNT - 1), $urandom_range(POOL - 1));
				end
			end else begin
				n--;
				send_req($urandom_range(1) ? KIND_SPARE_LO : KIND_SPARE_HI,
					$urandom_range(QCNT - 1), $urandom_range(POOL - 1), rand_prio());
			end
		end

		// misuse with no stimulus bookkeeping: double free, inserting linked entries, arbitrary codes
		repeat (NOISE_REQS)
			send_req(KIND_W'($urandom_range(7)), $urandom_range(QCNT - 1),
				$urandom_range(POOL - 1), PRIO_W'($urandom));

		req_ch.valid <= 1'b0;
		while (pending_count != 0) @(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

`default_nettype wire

/* sim.f */
rtl/core/epq_pkg.sv
rtl/core/epq_if.sv
rtl/core/entry_pool_priority_queues_core.sv
tb/epq_result_check.sv
tb/entry_pool_priority_queues_core_tb.sv
